[rtl/base32_stream_decoder_macros.svh]
// ---------------------------------------------------------------------------
// base32_stream_decoder_macros
// Assertion helpers for the Base32 stream decoder; empty for synthesis.
// ---------------------------------------------------------------------------
`ifndef BASE32_STREAM_DECODER_MACROS_SVH
`define BASE32_STREAM_DECODER_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every edge outside reset.
`define B32D_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition must never be seen outside reset.
`define B32D_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define B32D_ASSERT(lbl, clk, rst_n, prop, msg)
`define B32D_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

[rtl/b32d_pkg.sv]
// ---------------------------------------------------------------------------
// b32d_pkg
// Shared types and constants of the Base32 stream decoder.
// ---------------------------------------------------------------------------
package b32d_pkg;

	// character codes with a meaning of their own
	localparam logic [7:0] CHAR_SPACE  = 8'h20;
	localparam logic [7:0] CHAR_HYPHEN = 8'h2D;
	localparam logic [7:0] CHAR_PAD    = 8'h3D;
	localparam logic [7:0] CHAR_UPPER_A = 8'h41;
	localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
	localparam logic [7:0] CHAR_LOWER_A = 8'h61;
	localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
	localparam logic [7:0] CHAR_DIGIT_2 = 8'h32;
	localparam logic [7:0] CHAR_DIGIT_7 = 8'h37;
	// '2' maps to 26, so subtract ('2' - 26)
	localparam logic [7:0] DIGIT_OFFSET = CHAR_DIGIT_2 - 8'd26;

	localparam int SYM_W  = 5;
	localparam int BYTE_W = 8;
	localparam int STAT_W = 2;
	localparam int DATA_W = 16;   // byte + status, padded to whole bytes

	localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
	localparam logic [STAT_W-1:0] ST_INVALID = 2'd1;
	localparam logic [STAT_W-1:0] ST_EMPTY   = 2'd2;

	localparam int QUEUE_DEPTH_DEF = 4;

	typedef enum logic [1:0] {
		KIND_SYM  = 2'd0,
		KIND_SKIP = 2'd1,
		KIND_PAD  = 2'd2,
		KIND_BAD  = 2'd3
	} b32d_kind_t;

	// one classified character in the queue
	typedef struct packed {
		b32d_kind_t       kind;
		logic [SYM_W-1:0] sym;
		logic             last;
	} b32d_entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} b32d_queue_st_t;

	typedef struct packed {
		logic pop;    // head entry consumed this cycle
		logic clean;  // decode state at its string-start values
	} b32d_back_st_t;

endpackage

[rtl/base32_stream_decoder.sv]
// ---------------------------------------------------------------------------
// base32_stream_decoder
// Streaming Base32 (RFC 4648) text to byte decoder.
// ---------------------------------------------------------------------------
// Takes one character per transaction on the slave side and sustains one
// transaction per clock while the queue is not full. A classifier maps each
// character to a 5-bit symbol, a skip (space, hyphen), a pad ('=') or an
// invalid code and writes it into a QUEUE_DEPTH-entry register queue; the
// decode stage pops one entry per clock, while the output is not stalled,
// into a bit buffer and emits a byte whenever eight bits are held. The result
// for a character passes through its queue slot, written at the edge that
// accepts it, and then the output register. Letters of either case give
// 0..25, digits '2'..'7' give 26..31; the first '=' ends decoding for the
// rest of the string and any other character latches an error. The
// character marked by s_tlast always yields a result with m_tlast set and a
// status (0 ok, 1 invalid character seen, 2 no bytes produced), merged with
// a byte if that character completed one; the decoder then starts afresh.
// Characters that neither complete a byte nor end the string give no
// transaction. Leftover bits at the end are dropped. A stall on the master
// side fills the queue before s_tready falls.
// ---------------------------------------------------------------------------
module base32_stream_decoder #(
	parameter int QUEUE_DEPTH = b32d_pkg::QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// character input
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] char_code
	input  logic        s_tlast,   // is_last
	// decoded output
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [7:0] data_byte, [9:8] status, [15:10] zero
	output logic        m_tuser,   // byte_valid
	output logic        m_tlast    // is_final
);
	import b32d_pkg::*;

	`include "base32_stream_decoder_macros.svh"

	b32d_queue_st_t q_st;
	b32d_back_st_t  back_st;
	b32d_entry_t    wr_entry;
	b32d_entry_t    head;
	logic           wr_en;

	// classify and push
	b32d_front u_front (
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.q_st     (q_st),
		.wr_en    (wr_en),
		.wr_entry (wr_entry)
	);

	// decouples input acceptance from output stalls
	b32d_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_entry (wr_entry),
		.rd_en    (back_st.pop),
		.rd_entry (head),
		.q_st     (q_st)
	);

	// decode and deliver
	b32d_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (!q_st.empty),
		.head     (head),
		.back_st  (back_st),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	// a full queue must hold off the input side
	`B32D_NEVER(a_full_blocks_input, clk, arst_n, q_st.full && s_tready, "input ready while queue full")
	// a stalled result must not be overwritten by a pop
	`B32D_NEVER(a_no_pop_on_stall, clk, arst_n, back_st.pop && m_tvalid && !m_tready, "queue popped under output stall")
	// the end of a string leaves the decoder clean
	`B32D_ASSERT(a_clean_after_last, clk, arst_n, (back_st.pop && head.last) |=> back_st.clean, "decode state not cleared after last character")
	// nothing is popped from an empty queue
	`B32D_NEVER(a_no_pop_empty, clk, arst_n, back_st.pop && q_st.empty, "pop from empty queue")

endmodule

[rtl/b32d_front.sv]
// ---------------------------------------------------------------------------
// b32d_front
// Input side: takes characters and classifies them for the queue.
// ---------------------------------------------------------------------------
module b32d_front (
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [7:0]             s_tdata,   // [7:0] char_code
	input  logic                   s_tlast,   // is_last
	input  b32d_pkg::b32d_queue_st_t q_st,
	output logic                   wr_en,
	output b32d_pkg::b32d_entry_t  wr_entry
);
	import b32d_pkg::*;

	logic [7:0] diff;

	assign s_tready = !q_st.full;
	assign wr_en    = s_tvalid && !q_st.full;

	always_comb begin
		wr_entry.last = s_tlast;
		wr_entry.kind = KIND_BAD;
		diff          = '0;
		case (s_tdata) inside
			[CHAR_UPPER_A:CHAR_UPPER_Z]: begin
				wr_entry.kind = KIND_SYM;
				diff          = s_tdata - CHAR_UPPER_A;
			end
			[CHAR_LOWER_A:CHAR_LOWER_Z]: begin
				wr_entry.kind = KIND_SYM;
				diff          = s_tdata - CHAR_LOWER_A;
			end
			[CHAR_DIGIT_2:CHAR_DIGIT_7]: begin
				wr_entry.kind = KIND_SYM;
				diff          = s_tdata - DIGIT_OFFSET;
			end
			CHAR_SPACE, CHAR_HYPHEN: begin
				wr_entry.kind = KIND_SKIP;
			end
			CHAR_PAD: begin
				wr_entry.kind = KIND_PAD;
			end
			default: begin
				wr_entry.kind = KIND_BAD;
			end
		endcase
		wr_entry.sym = diff[SYM_W-1:0];
	end

endmodule

[rtl/b32d_queue.sv]
// ---------------------------------------------------------------------------
// b32d_queue
// Short register queue between the classifier and the decode stage.
// ---------------------------------------------------------------------------
module b32d_queue #(
	parameter int DEPTH = b32d_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     wr_en,
	input  b32d_pkg::b32d_entry_t    wr_entry,
	input  logic                     rd_en,
	output b32d_pkg::b32d_entry_t    rd_entry,
	output b32d_pkg::b32d_queue_st_t q_st
);
	import b32d_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	b32d_entry_t        slot_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;

	assign q_st.full  = (count_q == CNT_W'(DEPTH));
	assign q_st.empty = (count_q == '0);
	assign rd_entry   = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			slot_q[wr_ptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[rtl/b32d_back.sv]
// ---------------------------------------------------------------------------
// b32d_back
// Decode stage: bit gathering, mode tracking and the output register.
// ---------------------------------------------------------------------------
module b32d_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   q_valid,
	input  b32d_pkg::b32d_entry_t  head,
	output b32d_pkg::b32d_back_st_t back_st,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [15:0]            m_tdata,   // [7:0] data_byte, [9:8] status
	output logic                   m_tuser,   // byte_valid
	output logic                   m_tlast    // is_final
);
	import b32d_pkg::*;

	typedef enum logic [1:0] {
		MODE_RUNNING = 2'd0,
		MODE_STOPPED = 2'd1,
		MODE_ERROR   = 2'd2
	} mode_t;

	mode_t       mode_q, mode_d;
	logic [6:0]  buf_q, buf_d;     // at most seven bits pend between characters
	logic [2:0]  cnt_q, cnt_d;
	logic        prod_q, prod_d;

	logic [11:0] joined;
	logic [3:0]  cnt_sum;
	logic [3:0]  cnt_left;
	logic [11:0] shifted;
	logic        have_byte;
	logic [7:0]  byte_d;
	logic [STAT_W-1:0] status_d;
	logic        pop;

	assign pop         = q_valid && (!m_tvalid || m_tready);
	assign back_st.pop = pop;
	assign back_st.clean = (mode_q == MODE_RUNNING) && (cnt_q == '0) && !prod_q;

	always_comb begin
		joined    = {buf_q, head.sym};
		cnt_sum   = {1'b0, cnt_q} + 4'd5;
		cnt_left  = cnt_sum - 4'd8;
		shifted   = joined >> cnt_left[2:0];
		mode_d    = mode_q;
		buf_d     = buf_q;
		cnt_d     = cnt_q;
		prod_d    = prod_q;
		have_byte = 1'b0;
		byte_d    = '0;
		if (mode_q == MODE_RUNNING) begin
			case (head.kind)
				KIND_SYM: begin
					buf_d = joined[6:0];
					if (cnt_sum[3]) begin
						have_byte = 1'b1;
						byte_d    = shifted[7:0];
						cnt_d     = cnt_left[2:0];
						prod_d    = 1'b1;
					end else begin
						cnt_d = cnt_sum[2:0];
					end
				end
				KIND_PAD: mode_d = MODE_STOPPED;
				KIND_BAD: mode_d = MODE_ERROR;
				default:  mode_d = mode_q;
			endcase
		end
		if (mode_d == MODE_ERROR) begin
			status_d = ST_INVALID;
		end else if (!prod_d) begin
			status_d = ST_EMPTY;
		end else begin
			status_d = ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_RUNNING;
			buf_q    <= '0;
			cnt_q    <= '0;
			prod_q   <= 1'b0;
			m_tvalid <= 1'b0;
		end else begin
			if (pop) begin
				if (head.last) begin
					mode_q <= MODE_RUNNING;
					buf_q  <= '0;
					cnt_q  <= '0;
					prod_q <= 1'b0;
				end else begin
					mode_q <= mode_d;
					buf_q  <= buf_d;
					cnt_q  <= cnt_d;
					prod_q <= prod_d;
				end
				m_tvalid <= have_byte || head.last;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
		end
	end

	// payload, loaded only when a result is produced
	always_ff @(posedge clk) begin
		if (pop && (have_byte || head.last)) begin
			m_tdata <= {6'd0, (head.last ? status_d : ST_OK), byte_d};
			m_tuser <= have_byte;
			m_tlast <= head.last;
		end
	end

endmodule
